// ===== rtl/core/wsh_pkg.sv =====
package wsh_pkg;

   typedef enum logic [1:0] {
      MODE_SOFT   = 2'd0,
      MODE_HARD   = 2'd1,
      MODE_SINE   = 2'd2,
      MODE_BYPASS = 2'd3
   } mode_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SHAPE_MODE = 2'd0,
      CSR_DRIVE_GAIN = 2'd1,
      CSR_HARDNESS   = 2'd2,
      CSR_WET_MIX    = 2'd3
   } csr_index_type;

   typedef struct packed {
      mode_type    shape_mode;
      logic [15:0] drive_gain;
      logic [15:0] hardness;
      logic [15:0] wet_mix;
   } cfg_type;

   localparam int ONE_Q30 = 1 << 30;

   // Divider widths: dividend, divisor and quotient.
   localparam int NUM_W = 61;
   localparam int DEN_W = 43;
   localparam int QUO_W = 32;
   localparam int ARG_W = 31;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      mode_type           mode;
      logic signed [31:0] xs;
      logic [ARG_W-1:0]   arg;
      logic               use_quo;
      logic               inv;
      logic               neg;
   } tag_type;

   typedef struct packed {
      tag_type          tag;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Odd polynomials in Q30, highest order first.
   localparam logic signed [31:0] ATAN_COEF [5] = '{
      32'sd14242150, -32'sd58193962, 32'sd123138135, -32'sd225781269, 32'sd683473678
   };
   localparam logic signed [31:0] SIN_COEF [5] = '{
      32'sd172272, -32'sd5026995, 32'sd85569306, -32'sd693598668, 32'sd1686629713
   };

   function automatic logic signed [31:0] poly_coef(logic sine, int idx);
      return sine ? SIN_COEF[idx] : ATAN_COEF[idx];
   endfunction

   function automatic logic signed [31:0] horner_step(logic signed [31:0] p,
                                                      logic [ARG_W-1:0] a2,
                                                      logic signed [31:0] c);
      logic signed [63:0] prod;
      prod = 64'(p) * $signed({33'd0, a2});
      return 32'(prod >>> 30) + c;
   endfunction

endpackage

// ===== rtl/core/wsh_ifs.sv =====
interface wsh_req_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface wsh_rsp_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;
   logic                           saturated;
   modport source (output valid, output sample_out, output saturated, input ready);
   modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

// ===== rtl/core/distortion_waveshaper_unit.sv =====
// Stateless audio waveshaper: each transfer on req_chan carries one signed sample
// and yields exactly one transfer on rsp_chan, in order, with the shaped, wet/dry
// mixed and saturated sample and a flag for saturation. A new sample is taken every
// clock unless a full queue stalls the front; a sample passes 3 front stages, the
// queue, 33 stages of the pipelined restoring divider that serves the soft clip's
// reciprocal and the hard clip's scaling, 6 polynomial stages and 2 mix and output
// stages. The four-entry queue between front and back lets up to seven samples
// enter while rsp_chan is stalled. The user must write registers through csr_wr_en,
// csr_index and csr_wdata only while no sample is in flight (not enforced): 0 shape
// mode, 1 drive gain (Q6.10), 2 hardness (Q1.15), 3 wet mix (Q1.15).
module distortion_waveshaper_unit #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   wsh_req_if.sink                            req_chan,
   wsh_rsp_if.source                          rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [wsh_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wsh_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import wsh_pkg::*;

   localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   cfg_type    cfg_ff;
   q_stat_type q_stat;
   logic       q_push, q_pop;
   item_type   q_item_push, q_item_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shape_mode <= MODE_SOFT;
         cfg_ff.drive_gain <= 16'd1024;
         cfg_ff.hardness   <= 16'd0;
         cfg_ff.wet_mix    <= 16'd32768;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SHAPE_MODE: cfg_ff.shape_mode <= mode_type'(csr_wdata[1:0]);
            CSR_DRIVE_GAIN: cfg_ff.drive_gain <= csr_wdata;
            CSR_HARDNESS:   cfg_ff.hardness   <= csr_wdata;
            CSR_WET_MIX:    cfg_ff.wet_mix    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   wsh_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .q_stat   (q_stat),
      .push     (q_push),
      .item     (q_item_push)
   );

   wsh_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .item_in  (q_item_push),
      .pop      (q_pop),
      .item_out (q_item_pop),
      .q_stat   (q_stat)
   );

   wsh_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .item     (q_item_pop),
      .cfg      (cfg_ff),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   a_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !q_push)
      else $error("queue written while full");

   a_queue_underflow: assert property (@(posedge clock) disable iff (reset)
      q_stat.empty |-> !q_pop)
      else $error("queue read while empty");

   a_sat_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.saturated |->
         (rsp_chan.sample_out == S_MAX) || (rsp_chan.sample_out == S_MIN))
      else $error("saturation flag set on a sample that is not full scale");
`endif

endmodule

// ===== rtl/core/wsh_front.sv =====
module wsh_front #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   wsh_req_if.sink             req_chan,
   input  wsh_pkg::cfg_type    cfg,
   input  wsh_pkg::q_stat_type q_stat,
   output logic                push,
   output wsh_pkg::item_type   item
);
   import wsh_pkg::*;

   localparam int IN_SHIFT = 32 - SAMPLE_WIDTH;
   localparam logic [DEN_W-1:0] U_ONE = DEN_W'(1) << 30;

   logic               v1_ff, v2_ff, v3_ff;
   logic signed [31:0] xs1_ff, xs2_ff, xs3_ff;
   logic signed [37:0] d2_ff;
   logic signed [60:0] prod3_ff;
   logic [31:0]        mag3_ff;
   logic [15:0]        k3_ff;
   logic               dneg3_ff;
   logic               adv;

   logic signed [48:0] drv_prod;
   logic signed [37:0] d_in;
   logic [21:0]        coef_in;
   logic signed [60:0] prod_in;
   logic signed [17:0] hsub;
   logic [15:0]        k_in;
   logic [37:0]        dmag;
   logic [31:0]        lim;
   logic [31:0]        mag_in;

   logic signed [45:0] t;
   logic [45:0]        tmag;
   logic [DEN_W-1:0]   u;
   logic [1:0]         quad;
   logic [29:0]        f;

   // The front stalls only when its last stage holds an item the queue cannot take.
   assign adv = !(v3_ff && q_stat.full);
   assign req_chan.ready = adv;
   assign push = v3_ff && !q_stat.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign drv_prod = 49'(xs1_ff) * $signed({33'd0, cfg.drive_gain});
   assign d_in     = 38'(drv_prod >>> 10);

   assign coef_in = (cfg.shape_mode == MODE_SINE) ?
                    22'(cfg.hardness) * 22'd39 + 22'd32768 :
                    22'(cfg.hardness) * 22'd30 + 22'd32768;
   assign prod_in = 61'(d2_ff) * $signed({39'd0, coef_in});

   assign hsub   = 18'sd32768 - $signed({2'b00, cfg.hardness});
   assign k_in   = (hsub < 18'sd33) ? 16'd33 : hsub[15:0];
   assign dmag   = d2_ff[37] ? 38'(-d2_ff) : 38'(d2_ff);
   assign lim    = {k_in, 16'd0};
   assign mag_in = (dmag > {6'd0, lim}) ? lim : dmag[31:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         xs1_ff   <= 32'(req_chan.sample_in) <<< IN_SHIFT;
         xs2_ff   <= xs1_ff;
         d2_ff    <= d_in;
         xs3_ff   <= xs2_ff;
         prod3_ff <= prod_in;
         mag3_ff  <= mag_in;
         k3_ff    <= k_in;
         dneg3_ff <= d2_ff[37];
      end
   end

   assign t    = 46'(prod3_ff >>> 15);
   assign tmag = t[45] ? 46'(-t) : 46'(t);
   assign u    = tmag[43:1];
   assign quad = prod3_ff[48:47];
   assign f    = prod3_ff[46:17];

   always_comb begin
      item = '0;
      item.tag.mode = cfg.shape_mode;
      item.tag.xs = xs3_ff;
      item.den = DEN_W'(1);
      case (cfg.shape_mode)
         MODE_SOFT: begin
            item.tag.neg = t[45];
            // Beyond one the curve is taken from its reciprocal argument.
            if (u > U_ONE) begin
               item.num = NUM_W'(1) << 60;
               item.den = u;
               item.tag.use_quo = 1'b1;
               item.tag.inv = 1'b1;
            end else begin
               item.tag.arg = u[ARG_W-1:0];
            end
         end
         MODE_HARD: begin
            item.num = {14'd0, mag3_ff, 15'd0};
            item.den = {27'd0, k3_ff};
            item.tag.neg = dneg3_ff;
         end
         MODE_SINE: begin
            item.tag.neg = quad[1];
            item.tag.arg = quad[0] ? ARG_W'(ONE_Q30) - {1'b0, f} : {1'b0, f};
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/core/wsh_queue.sv =====
module wsh_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wsh_pkg::item_type   item_in,
   input  logic                pop,
   output wsh_pkg::item_type   item_out,
   output wsh_pkg::q_stat_type q_stat
);
   import wsh_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type       mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff, count_in;

   assign item_out     = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= item_in;
   end

endmodule

// ===== rtl/core/wsh_div.sv =====
module wsh_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [wsh_pkg::NUM_W-1:0]     in_num,
   input  logic [wsh_pkg::DEN_W-1:0]     in_den,
   input  wsh_pkg::tag_type              in_tag,
   output logic                          out_valid,
   output logic [wsh_pkg::QUO_W-1:0]     out_quo,
   output wsh_pkg::tag_type              out_tag
);
   import wsh_pkg::*;

   localparam int STEPS = QUO_W;

   logic [STEPS:0]   v_ff;
   logic [DEN_W-1:0] rem_ff [STEPS+1];
   logic [QUO_W-1:0] nl_ff [STEPS+1];
   logic [QUO_W-1:0] q_ff [STEPS+1];
   logic [DEN_W-1:0] den_ff [STEPS+1];
   tag_type          tag_ff [STEPS+1];
   logic [DEN_W:0]   step_w [STEPS];

   // One restoring step: the remainder is always below the divisor.
   function automatic logic [DEN_W:0] div_step(logic [DEN_W-1:0] rem, logic nbit,
                                               logic [DEN_W-1:0] den);
      logic [DEN_W:0] trial;
      logic           ge;
      trial = {rem, nbit};
      ge = (trial >= {1'b0, den});
      if (ge) trial = trial - {1'b0, den};
      return {trial[DEN_W-1:0], ge};
   endfunction

   always_comb begin
      for (int i = 1; i <= STEPS; i++) begin
         step_w[i-1] = div_step(rem_ff[i-1], nl_ff[i-1][QUO_W-1], den_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[STEPS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DEN_W'(in_num[NUM_W-1:QUO_W]);
         nl_ff[0]  <= in_num[QUO_W-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= in_den;
         tag_ff[0] <= in_tag;
         for (int i = 1; i <= STEPS; i++) begin
            rem_ff[i] <= step_w[i-1][DEN_W:1];
            nl_ff[i]  <= nl_ff[i-1] << 1;
            q_ff[i]   <= {q_ff[i-1][QUO_W-2:0], step_w[i-1][0]};
            den_ff[i] <= den_ff[i-1];
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   assign out_valid = v_ff[STEPS];
   assign out_quo   = q_ff[STEPS];
   assign out_tag   = tag_ff[STEPS];

endmodule

// ===== rtl/core/wsh_back.sv =====
module wsh_back #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  wsh_pkg::q_stat_type q_stat,
   input  wsh_pkg::item_type   item,
   input  wsh_pkg::cfg_type    cfg,
   output logic                pop,
   wsh_rsp_if.source           rsp_chan
);
   import wsh_pkg::*;

   localparam int PS          = 6;
   localparam int IN_SHIFT    = 32 - SAMPLE_WIDTH;
   localparam int IN_SHIFT_M1 = (IN_SHIFT > 0) ? IN_SHIFT - 1 : 0;
   localparam logic signed [37:0] RND = (IN_SHIFT > 0) ? (38'sd1 <<< IN_SHIFT_M1) : 38'sd0;
   localparam logic signed [37:0] HI  = (38'sd1 <<< (SAMPLE_WIDTH - 1)) - 38'sd1;
   localparam logic signed [37:0] LO  = -(38'sd1 <<< (SAMPLE_WIDTH - 1));

   logic             en;
   logic             dv;
   logic [QUO_W-1:0] dq;
   tag_type          dt;

   logic [PS-1:0]      pv_ff;
   logic [ARG_W-1:0]   pa_ff [PS-1];
   logic [ARG_W-1:0]   pa2_ff [PS-1];
   logic signed [31:0] pp_ff [PS];
   logic [QUO_W-1:0]   pq_ff [PS];
   tag_type            pt_ff [PS];

   logic [ARG_W-1:0]   a_sel;
   logic [61:0]        sq;
   logic signed [63:0] r_prod;
   logic signed [31:0] r_in;

   logic signed [33:0] r34, quo34, m, y;
   logic signed [17:0] wdry;
   logic signed [50:0] py_in;
   logic signed [49:0] px_in;
   tag_type            t5;

   logic               yv_ff;
   logic signed [50:0] py_ff;
   logic signed [49:0] px_ff;
   mode_type           ym_ff;
   logic signed [31:0] yxs_ff;

   logic signed [51:0] sum;
   logic signed [36:0] v;
   logic signed [37:0] vr;

   logic                           out_v_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_s_ff, out_s_in;
   logic                           out_sat_ff, out_sat_in;

   // The whole back pipeline advances together unless a result is held at the output.
   assign en  = !out_v_ff || rsp_chan.ready;
   assign pop = en && !q_stat.empty;

   wsh_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pop),
      .in_num    (item.num),
      .in_den    (item.den),
      .in_tag    (item.tag),
      .out_valid (dv),
      .out_quo   (dq),
      .out_tag   (dt)
   );

   assign a_sel  = dt.use_quo ? dq[ARG_W-1:0] : dt.arg;
   assign sq     = 62'(a_sel) * 62'(a_sel);
   assign r_prod = 64'(pp_ff[PS-2]) * $signed({33'd0, pa_ff[PS-2]});
   assign r_in   = 32'(r_prod >>> 30);

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff    <= '0;
         yv_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         pv_ff    <= {pv_ff[PS-2:0], dv};
         yv_ff    <= pv_ff[PS-1];
         out_v_ff <= yv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff[0]  <= a_sel;
         pa2_ff[0] <= sq[60:30];
         pp_ff[0]  <= poly_coef(dt.mode == MODE_SINE, 0);
         pq_ff[0]  <= dq;
         pt_ff[0]  <= dt;
         for (int i = 1; i < PS - 1; i++) begin
            pa_ff[i]  <= pa_ff[i-1];
            pa2_ff[i] <= pa2_ff[i-1];
            pp_ff[i]  <= horner_step(pp_ff[i-1], pa2_ff[i-1],
                                     poly_coef(pt_ff[i-1].mode == MODE_SINE, i));
         end
         pp_ff[PS-1] <= r_in;
         for (int i = 1; i < PS; i++) begin
            pq_ff[i] <= pq_ff[i-1];
            pt_ff[i] <= pt_ff[i-1];
         end
      end
   end

   assign t5    = pt_ff[PS-1];
   assign r34   = 34'(pp_ff[PS-1]);
   assign quo34 = $signed({2'b00, pq_ff[PS-1]});

   always_comb begin
      m = r34;
      case (t5.mode)
         MODE_SOFT: begin
            if (t5.inv) m = 34'(ONE_Q30) - r34;
            if (t5.neg) m = -m;
            y = m <<< 1;
         end
         MODE_HARD: begin
            y = t5.neg ? -quo34 : quo34;
         end
         MODE_SINE: begin
            if (t5.neg) m = -r34;
            y = m <<< 1;
         end
         default: begin
            y = '0;
         end
      endcase
   end

   assign wdry  = 18'sd32768 - $signed({2'b00, cfg.wet_mix});
   assign py_in = 51'(y) * $signed({35'd0, cfg.wet_mix});
   assign px_in = 50'($signed(t5.xs)) * 50'(wdry);

   always_ff @(posedge clock) begin
      if (en) begin
         py_ff  <= py_in;
         px_ff  <= px_in;
         ym_ff  <= t5.mode;
         yxs_ff <= t5.xs;
      end
   end

   assign sum = 52'(py_ff) + 52'(px_ff);
   assign v   = 37'(sum >>> 15);
   assign vr  = (38'(v) + RND) >>> IN_SHIFT;

   always_comb begin
      out_sat_in = 1'b0;
      if (ym_ff == MODE_BYPASS) begin
         out_s_in = yxs_ff[31 -: SAMPLE_WIDTH];
      end else if (vr > HI) begin
         out_s_in   = HI[SAMPLE_WIDTH-1:0];
         out_sat_in = 1'b1;
      end else if (vr < LO) begin
         out_s_in   = LO[SAMPLE_WIDTH-1:0];
         out_sat_in = 1'b1;
      end else begin
         out_s_in = vr[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_s_ff   <= out_s_in;
         out_sat_ff <= out_sat_in;
      end
   end

   assign rsp_chan.valid      = out_v_ff;
   assign rsp_chan.sample_out = out_s_ff;
   assign rsp_chan.saturated  = out_sat_ff;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import wsh_pkg::*;

   typedef struct {
      logic signed [15:0] sample;
      logic               sat;
   } shaped_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   wsh_req_if #(.SAMPLE_WIDTH(16)) req_if ();
   wsh_rsp_if #(.SAMPLE_WIDTH(16)) rsp_if ();

   distortion_waveshaper_unit #(.SAMPLE_WIDTH(16)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   localparam int DRAIN_CYCLES = 80;
   localparam longint CYCLE_LIMIT = 2000000;

   // Our own copy of the register file.
   mode_type    cur_mode;
   logic [15:0] cur_drive;
   logic [15:0] cur_hard;
   logic [15:0] cur_mix;

   shaped_type expected_q[$];
   int  errors = 0;
   int  samples_sent = 0;
   int  results_seen = 0;
   int  sat_seen = 0;
   int  rsp_hold = 0;
   bit  steady_flow = 0;
   longint cycles = 0;

   always #6 clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.sample_in = '0;
      rsp_if.ready = 1'b0;
   end

   // Floor shift on a signed 64-bit value.
   function automatic longint fshr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint atan_curve(longint u);
      longint u2, p;
      u2 = fshr(u * u, 30);
      p = 14242150;
      p = fshr(p * u2, 30) - 58193962;
      p = fshr(p * u2, 30) + 123138135;
      p = fshr(p * u2, 30) - 225781269;
      p = fshr(p * u2, 30) + 683473678;
      return fshr(p * u, 30);
   endfunction

   function automatic longint sine_curve(longint f);
      longint f2, p;
      f2 = fshr(f * f, 30);
      p = 172272;
      p = fshr(p * f2, 30) - 5026995;
      p = fshr(p * f2, 30) + 85569306;
      p = fshr(p * f2, 30) - 693598668;
      p = fshr(p * f2, 30) + 1686629713;
      return fshr(p * f, 30);
   endfunction

   function automatic shaped_type shape_sample(logic signed [15:0] x);
      shaped_type r;
      longint xs, d, y, v, t, u, k, lim, q, ph, f, hv, mv;
      int quad;
      hv = longint'(cur_hard);
      mv = longint'(cur_mix);
      r.sat = 1'b0;
      if (cur_mode == MODE_BYPASS) begin
         r.sample = x;
         return r;
      end
      xs = longint'(x) * 65536;
      d = fshr(xs * longint'(cur_drive), 10);
      case (cur_mode)
         MODE_SOFT: begin
            t = fshr(d * (30 * hv + 32768), 15);
            u = (t < 0 ? -t : t) >>> 1;
            if (u <= (longint'(1) << 30)) y = atan_curve(u);
            else y = (longint'(1) << 30) - atan_curve((longint'(1) << 60) / u);
            if (t < 0) y = -y;
            y = y * 2;
         end
         MODE_HARD: begin
            k = 32768 - hv;
            if (k < 33) k = 33;
            lim = k * 65536;
            if (d > lim) d = lim;
            if (d < -lim) d = -lim;
            y = (d * 32768) / k;
         end
         default: begin
            q = fshr(d * (39 * hv + 32768), 16);
            ph = q & ((longint'(1) << 33) - 1);
            quad = int'(ph >>> 31);
            f = (ph & ((longint'(1) << 31) - 1)) >>> 1;
            if (quad[0]) y = sine_curve((longint'(1) << 30) - f);
            else y = sine_curve(f);
            if (quad[1]) y = -y;
            y = y * 2;
         end
      endcase
      v = fshr(y * mv + xs * (32768 - mv), 15);
      v = fshr(v + 32768, 16);
      if (v > 32767) begin
         v = 32767;
         r.sat = 1'b1;
      end else if (v < -32768) begin
         v = -32768;
         r.sat = 1'b1;
      end
      r.sample = 16'(v);
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off when requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready = 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_if.ready = 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_if.ready = steady_flow || ($urandom_range(99) >= 19);
      end
   end

   always @(posedge clock) begin
      shaped_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (rsp_if.saturated) sat_seen++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result sample=%0d sat=%0b", $time,
                     rsp_if.sample_out, rsp_if.saturated);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_if.sample_out !== want.sample) begin
               $display("%0t: sample_out expected %0d actual %0d", $time,
                        want.sample, rsp_if.sample_out);
               errors++;
            end
            if (rsp_if.saturated !== want.sat) begin
               $display("%0t: saturated expected %0b actual %0b", $time,
                        want.sat, rsp_if.saturated);
               errors++;
            end
         end
      end
   end

   task automatic send_sample(logic signed [15:0] s);
      while (!steady_flow && $urandom_range(99) < 19) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.sample_in = s;
      do @(posedge clock); while (!req_if.ready);
      expected_q.push_back(shape_sample(s));
      samples_sent++;
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   task automatic wait_idle();
      req_if.valid = 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] value);
      wait_idle();
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_SHAPE_MODE: cur_mode = mode_type'(value[1:0]);
         CSR_DRIVE_GAIN: cur_drive = value;
         CSR_HARDNESS:   cur_hard = value;
         default:        cur_mix = value;
      endcase
   endtask

   task automatic set_config(mode_type m, logic [15:0] drv, logic [15:0] hd,
                             logic [15:0] mx);
      write_reg(CSR_SHAPE_MODE, 16'(m));
      write_reg(CSR_DRIVE_GAIN, drv);
      write_reg(CSR_HARDNESS, hd);
      write_reg(CSR_WET_MIX, mx);
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(3))
         0: return 16'($urandom_range(65535));
         1: return 16'(int'($urandom_range(1023)) - 512);
         2: return $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(15))
                                     : 16'sh8000 + 16'($urandom_range(15));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      logic signed [15:0] edge_vals [6] = '{16'sh7fff, 16'sh8000, 16'sh0000,
                                            16'sh0001, 16'shffff, 16'sh4000};
      mode_type m;
      // Reset values first: soft clip, unity drive, full wet.
      foreach (edge_vals[i]) send_sample(edge_vals[i]);
      m = MODE_SOFT;
      do begin
         set_config(m, 16'd1024, 16'd0, 16'd32768);
         send_sample(16'sh7fff);
         send_sample(16'sh8000);
         send_sample(16'sh1234);
         m = m.next();
      end while (m != MODE_SOFT);
      // Hardness above one and mix above one, which forces saturation.
      set_config(MODE_HARD, 16'hffff, 16'hffff, 16'hffff);
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      send_sample(16'sh0003);
   endtask

   task automatic test_random_configs(int n_items);
      int per_set;
      int done = 0;
      while (done < n_items) begin
         case ($urandom_range(4))
            0: set_config(mode_type'($urandom_range(3)), 16'hffff, 16'd32768, 16'd0);
            1: set_config(mode_type'($urandom_range(3)), 16'd0, 16'd0, 16'd32768);
            2: set_config(mode_type'($urandom_range(3)), 16'($urandom),
                          16'($urandom), 16'($urandom));
            default: set_config(mode_type'($urandom_range(3)),
                                16'($urandom_range(8192)), 16'($urandom_range(32768)),
                                16'($urandom_range(32768)));
         endcase
         steady_flow = ($urandom_range(5) == 0);
         per_set = $urandom_range(40, 120);
         repeat (per_set) send_sample(rand_sample());
         steady_flow = 0;
         done += per_set;
      end
   endtask

   task automatic test_backpressure();
      set_config(MODE_SINE, 16'd5000, 16'd20000, 16'd24000);
      @(negedge clock);
      rsp_hold = 300;
      // More samples than the whole pipeline holds, so the input stalls.
      repeat (100) send_sample(rand_sample());
      // The sender stops here until the pipeline has delivered everything.
      wait_idle();
      repeat (20) send_sample(rand_sample());
   endtask

   initial begin
      cur_mode = MODE_SOFT;
      cur_drive = 16'd1024;
      cur_hard = 16'd0;
      cur_mix = 16'd32768;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_backpressure();
      test_random_configs(1400);
      wait_idle();
      $display("Sent %0d samples over many register settings in all four shapes;",
               samples_sent);
      $display("checked %0d results, %0d of them saturated.", results_seen, sat_seen);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
